>>> design/calendar_date_to_epoch_seconds_macros.svh
// Assertion macros for the date to epoch seconds block.
// Used by the port checker; relies on clk and rst_n in the scope of use.
`ifndef CALENDAR_DATE_TO_EPOCH_SECONDS_MACROS_SVH
`define CALENDAR_DATE_TO_EPOCH_SECONDS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CDTE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdte check failed");

// Next-cycle implication, checked out of reset.
`define CDTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdte check failed");

`endif

>>> design/cdte_pkg.sv
// Shared types, constants and calendar functions for the date to epoch block.
// No dependencies.
`default_nettype none

package cdte_pkg;

    localparam logic [11:0] YEAR_FIRST = 12'd1970;
    localparam logic [11:0] YEAR_LAST  = 12'd2099;

    localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
    localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
    localparam logic [31:0] SECS_DAY         = 32'd86400;
    localparam logic [31:0] SECS_HOUR        = 32'd3600;
    localparam logic [31:0] SECS_MINUTE      = 32'd60;

    // Accumulator start value: minus one day, so day one adds nothing.
    localparam logic [31:0] ACC_INIT = 32'd0 - SECS_DAY;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_SEC,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_YEAR,
        OP_MONTH,
        OP_DAY,
        OP_HOUR,
        OP_MIN,
        OP_SEC
    } op_t;

    // Sequencer to datapath control.
    typedef struct packed {
        logic       load;
        op_t        op;
        logic       leap;
        logic [3:0] mon;
        logic       err;
    } ctrl_t;

    // Leap year for 1970..2099: the only century in range is 2000, which is
    // divisible by 400, so the divisible-by-four rule alone is exact here.
    function automatic logic leap_year(input logic [11:0] y);
        return (y[1:0] == 2'b00);
    endfunction

    // Length in seconds of a whole month.
    function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
        logic [31:0] secs;
        unique case (m) inside
            MON_JAN, MON_MAR, MON_MAY, MON_JUL,
            MON_AUG, MON_OCT, MON_DEC:          secs = 32'd31 * SECS_DAY;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: secs = 32'd30 * SECS_DAY;
            MON_FEB:                            secs = leap ? 32'd29 * SECS_DAY
                                                            : 32'd28 * SECS_DAY;
            default:                            secs = 32'd0;
        endcase
        return secs;
    endfunction

endpackage

`default_nettype wire

>>> design/cdte_seq.sv
// Sequencer: range check, year and month counters, step order.
// Depends on cdte_pkg.
`default_nettype none

module cdte_seq
    import cdte_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [11:0] year,
    input  wire logic [3:0]  month,
    output      logic        busy,
    output      logic        done,
    output      ctrl_t       ctrl
);

    state_t      state_reg, state_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [11:0] ycnt_reg, ycnt_next;
    logic [3:0]  mcnt_reg, mcnt_next;
    logic        err_reg, err_next;
    logic        bad;

    assign bad = (year < YEAR_FIRST) || (year > YEAR_LAST)
              || (month == 4'd0) || (month > MON_DEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            year_reg  <= '0;
            month_reg <= '0;
            ycnt_reg  <= '0;
            mcnt_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            year_reg  <= year_next;
            month_reg <= month_next;
            ycnt_reg  <= ycnt_next;
            mcnt_reg  <= mcnt_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        year_next  = year_reg;
        month_next = month_reg;
        ycnt_next  = ycnt_reg;
        mcnt_next  = mcnt_reg;
        err_next   = err_reg;
        ctrl.load  = 1'b0;
        ctrl.op    = OP_NONE;
        ctrl.leap  = leap_year(year_reg);
        ctrl.mon   = mcnt_reg;
        ctrl.err   = err_reg;
        busy       = (state_reg != ST_IDLE);
        done       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    year_next  = year;
                    month_next = month;
                    ycnt_next  = YEAR_FIRST;
                    mcnt_next  = MON_JAN;
                    err_next   = bad;
                    state_next = bad ? ST_DONE : ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                ctrl.leap = leap_year(ycnt_reg);
                if (ycnt_reg == year_reg)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    ctrl.op   = OP_YEAR;
                    ycnt_next = ycnt_reg + 12'd1;
                end
            end
            ST_MONTH:
            begin
                if (mcnt_reg == month_reg)
                begin
                    state_next = ST_DAY;
                end
                else
                begin
                    ctrl.op   = OP_MONTH;
                    mcnt_next = mcnt_reg + 4'd1;
                end
            end
            ST_DAY:
            begin
                ctrl.op    = OP_DAY;
                state_next = ST_HOUR;
            end
            ST_HOUR:
            begin
                ctrl.op    = OP_HOUR;
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                ctrl.op    = OP_MIN;
                state_next = ST_SEC;
            end
            ST_SEC:
            begin
                ctrl.op    = OP_SEC;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/cdte_dp.sv
// Datapath: request field holding registers, addend select, shared adder.
// Depends on cdte_pkg.
`default_nettype none

module cdte_dp
    import cdte_pkg::*;
(
    input  wire logic        clk,
    input  wire ctrl_t       ctrl,
    input  wire logic [4:0]  day,
    input  wire logic [4:0]  hour_of_day,
    input  wire logic [5:0]  minute,
    input  wire logic [5:0]  second,
    output      logic [31:0] epoch_seconds,
    output      logic        range_error
);

    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  min_reg;
    logic [5:0]  sec_reg;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] addend;

    always_comb
    begin
        case (ctrl.op)
            OP_YEAR:  addend = ctrl.leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            OP_MONTH: addend = month_secs(ctrl.mon, ctrl.leap);
            OP_DAY:   addend = 32'(day_reg) * SECS_DAY;
            OP_HOUR:  addend = 32'(hour_reg) * SECS_HOUR;
            OP_MIN:   addend = 32'(min_reg) * SECS_MINUTE;
            OP_SEC:   addend = 32'(sec_reg);
            default:  addend = 32'd0;
        endcase
        acc_next = ctrl.load ? ACC_INIT : acc_reg + addend;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctrl.load)
        begin
            day_reg  <= day;
            hour_reg <= hour_of_day;
            min_reg  <= minute;
            sec_reg  <= second;
        end
    end

    // Drop the sum on a rejected request.
    assign epoch_seconds = ctrl.err ? 32'd0 : acc_reg;
    assign range_error   = ctrl.err;

endmodule

`default_nettype wire

>>> design/calendar_date_to_epoch_seconds.sv
// Top level of the calendar date to epoch seconds converter.
// Depends on cdte_pkg, cdte_seq and cdte_dp.
`default_nettype none

// Usage
//   Request channel: drive year, month, day, hour_of_day, minute and second
//   and raise start; the request is taken at a rising edge where start is
//   high and busy is low. Fields are captured then and need not be held.
//   Result channel: done is high for exactly one cycle with epoch_seconds and
//   range_error valid in that cycle. The receiver cannot stall, so it must
//   take the result in that cycle.
//   Operation: one shared 32-bit adder accumulates, one addend per cycle, under
//   the sequencer. A good request walks the years from 1970 up to year, then
//   the months from January up to month, then adds day, hour, minute and
//   second in turn, then shows done. A request with year outside 1970..2099
//   or month outside 1..12 goes straight to done and reports range_error
//   with zero seconds.
//   Throughput: one request at a time; busy stays high until done has shown,
//   so the next request can be taken the cycle after done.
//   Reset: rst_n low returns the sequencer to idle at once; no request is
//   in flight afterwards and done stays low.
//   Day zero and oversized day, hour, minute or second are summed without
//   check, modulo 2^32.

module calendar_date_to_epoch_seconds
    import cdte_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [11:0] year,
    input  wire logic [3:0]  month,
    input  wire logic [4:0]  day,
    input  wire logic [4:0]  hour_of_day,
    input  wire logic [5:0]  minute,
    input  wire logic [5:0]  second,
    output      logic        done,
    output      logic [31:0] epoch_seconds,
    output      logic        range_error
);

    ctrl_t ctrl;

    // Sequencer: checks the range, walks years then months, then the tail.
    cdte_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .year  (year),
        .month (month),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    // Datapath: holds the request fields and the running sum.
    cdte_dp u_dp (
        .clk           (clk),
        .ctrl          (ctrl),
        .day           (day),
        .hour_of_day   (hour_of_day),
        .minute        (minute),
        .second        (second),
        .epoch_seconds (epoch_seconds),
        .range_error   (range_error)
    );

endmodule

`default_nettype wire

>>> design/cdte_checker.sv
// Port-level checker for the date to epoch converter, with its bind.
// Depends on calendar_date_to_epoch_seconds_macros.svh.
`default_nettype none

`include "calendar_date_to_epoch_seconds_macros.svh"

module cdte_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] epoch_seconds,
    input wire logic        range_error
);

    `CDTE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `CDTE_ASSERT_IMPL(a_done_in_busy, done, busy)
    `CDTE_ASSERT_NEXT(a_done_single, done, !done && !busy)
    `CDTE_ASSERT_IMPL(a_err_zero, done && range_error, epoch_seconds == 32'd0)

endmodule

bind calendar_date_to_epoch_seconds cdte_checker u_cdte_checker (.*);

`default_nettype wire

>>> verif/tb_calendar_date_to_epoch_seconds.sv
// Self-checking testbench for calendar_date_to_epoch_seconds.
// Drives date requests in random bursts, predicts each conversion in-bench and
// checks every done strobe against it; needs cdte_pkg and the RTL only.

module tb_calendar_date_to_epoch_seconds;
    import cdte_pkg::*;

    // Watch time after the last result: a margin on top of the longest conversion.
    localparam int unsigned DRAIN_CYCLES  = 200;
    localparam int unsigned LIMIT_CYCLES  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef struct {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } date_req_t;

    typedef struct {
        logic [31:0] seconds;
        logic        range_error;
    } epoch_result_t;

    // Drive every input to a known value from time zero.
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [11:0] year        = '0;
    logic [3:0]  month       = '0;
    logic [4:0]  day         = '0;
    logic [4:0]  hour_of_day = '0;
    logic [5:0]  minute      = '0;
    logic [5:0]  second      = '0;
    logic        busy;
    logic        done;
    logic [31:0] epoch_seconds;
    logic        range_error;

    // Requests not yet accepted; the front one is on the ports whenever start is high.
    date_req_t     pending_dates[$];
    // Conversions accepted by the block whose done strobe is still due.
    epoch_result_t expected_epochs[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned burst_left     = 0;
    int unsigned gap_left       = 0;

    calendar_date_to_epoch_seconds uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour_of_day   (hour_of_day),
        .minute        (minute),
        .second        (second),
        .done          (done),
        .epoch_seconds (epoch_seconds),
        .range_error   (range_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Full Gregorian rule, centuries included, so the bench does not lean on
    // the narrower year range the block assumes.
    function automatic bit is_leap(input int unsigned y);
        if ((y % 4) != 0)
            return 1'b0;
        if ((y % 100) != 0)
            return 1'b1;
        return (y % 400) == 0;
    endfunction

    // Seconds since the epoch for one date request, wrapping modulo 2^32.
    function automatic epoch_result_t predict_epoch(input date_req_t d);
        epoch_result_t r;
        logic [31:0]   total;
        int unsigned   y;
        int unsigned   m;
        int unsigned   mdays;
        r.seconds     = '0;
        r.range_error = 1'b1;
        if (d.year < YEAR_FIRST || d.year > YEAR_LAST || d.month < MON_JAN ||
            d.month > MON_DEC)
            return r;
        total = '0;
        for (y = YEAR_FIRST; y < d.year; y++)
            total += is_leap(y) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
        for (m = MON_JAN; m < d.month; m++)
        begin
            case (m) inside
                MON_FEB:                            mdays = is_leap(d.year) ? 29 : 28;
                MON_APR, MON_JUN, MON_SEP, MON_NOV: mdays = 30;
                default:                            mdays = 31;
            endcase
            total += 32'(mdays) * SECS_DAY;
        end
        // Day zero lands on the day before the first and may wrap below zero.
        total += (32'(d.day) - 32'd1) * SECS_DAY;
        total += 32'(d.hour) * SECS_HOUR;
        total += 32'(d.minute) * SECS_MINUTE;
        total += 32'(d.second);
        r.seconds     = total;
        r.range_error = 1'b0;
        return r;
    endfunction

    task automatic queue_date(input int unsigned y, input int unsigned mo,
                              input int unsigned d, input int unsigned h,
                              input int unsigned mi, input int unsigned s);
        date_req_t r;
        r.year   = 12'(y);
        r.month  = 4'(mo);
        r.day    = 5'(d);
        r.hour   = 5'(h);
        r.minute = 6'(mi);
        r.second = 6'(s);
        pending_dates.push_back(r);
    endtask

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Mostly back-to-back, sometimes short pauses, now and then long enough to
    // cover a whole conversion so idle time lands on every phase.
    function automatic int unsigned pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 0;
        if (sel < 80)
            return $urandom_range(1, 5);
        if (sel < 95)
            return $urandom_range(6, 60);
        return $urandom_range(61, 160);
    endfunction

    // Driver: retire the request taken at this edge, then present the next.
    // start gets exactly one nonblocking assignment per edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_epochs.push_back(predict_epoch(pending_dates[0]));
                pending_dates.delete(0);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left   = pick_gap();
                    burst_left = $urandom_range(1, 12);
                end
            end
            if (start && busy)
            begin
                // Hold the request and its fields until the block takes it.
                start <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start       <= 1'b0;
                // Wiggle the fields while idle; the block must ignore them.
                year        <= 12'($urandom);
                month       <= 4'($urandom);
                day         <= 5'($urandom);
                hour_of_day <= 5'($urandom);
                minute      <= 6'($urandom);
                second      <= 6'($urandom);
            end
            else if (pending_dates.size() > 0)
            begin
                start       <= 1'b1;
                year        <= pending_dates[0].year;
                month       <= pending_dates[0].month;
                day         <= pending_dates[0].day;
                hour_of_day <= pending_dates[0].hour;
                minute      <= pending_dates[0].minute;
                second      <= pending_dates[0].second;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every done strobe must match the oldest outstanding request.
    always @(posedge clk)
    begin
        epoch_result_t want;
        if (rst_n && done)
        begin
            if (expected_epochs.size() == 0)
            begin
                report($sformatf("unexpected result: epoch_seconds %0d range_error %0b",
                                 epoch_seconds, range_error));
            end
            else
            begin
                want = expected_epochs.pop_front();
                if (epoch_seconds !== want.seconds)
                    report($sformatf("epoch_seconds mismatch: got %0d expected %0d",
                                     epoch_seconds, want.seconds));
                if (range_error !== want.range_error)
                    report($sformatf("range_error mismatch: got %0b expected %0b",
                                     range_error, want.range_error));
            end
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned kind;
        int unsigned yr;
        int unsigned mo;
        int unsigned hr;

        // Directed: epoch start, day zero wrap, range edges, leap handling
        // and unchecked overflow of day, hour, minute and second.
        queue_date(1970, 1, 1, 0, 0, 0);
        queue_date(1970, 1, 0, 0, 0, 0);
        queue_date(2099, 12, 31, 23, 59, 59);
        queue_date(2099, 12, 31, 31, 63, 63);
        queue_date(2099, 12, 0, 0, 0, 0);
        queue_date(1969, 12, 31, 23, 59, 59);
        queue_date(2100, 1, 1, 0, 0, 0);
        queue_date(0, 0, 0, 0, 0, 0);
        queue_date(4095, 15, 31, 31, 63, 63);
        queue_date(2000, 0, 15, 12, 30, 30);
        queue_date(2000, 13, 1, 0, 0, 0);
        queue_date(2000, 15, 1, 0, 0, 0);
        queue_date(2000, 2, 29, 12, 0, 0);
        queue_date(2000, 3, 1, 0, 0, 0);
        queue_date(1972, 2, 29, 0, 0, 0);
        queue_date(1972, 3, 1, 0, 0, 0);
        queue_date(2099, 3, 1, 0, 0, 0);
        queue_date(2096, 12, 31, 23, 59, 59);
        queue_date(2038, 1, 19, 3, 14, 7);
        queue_date(1970, 2, 31, 0, 0, 0);
        queue_date(1970, 12, 31, 31, 63, 63);
        queue_date(1970, 1, 31, 0, 63, 63);
        queue_date(2024, 6, 15, 31, 0, 0);

        // Random: mostly in-range dates, the rest out-of-range year or month.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 99);
            yr   = $urandom_range(YEAR_FIRST, YEAR_LAST);
            mo   = $urandom_range(MON_JAN, MON_DEC);
            if (kind < 4)
                yr = $urandom_range(0, YEAR_FIRST - 1);
            else if (kind < 8)
                yr = $urandom_range(YEAR_LAST + 1, 4095);
            else if (kind < 11)
                mo = 0;
            else if (kind < 15)
                mo = $urandom_range(MON_DEC + 1, 15);
            hr = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
            queue_date(yr, mo, $urandom_range(0, 31), hr, $urandom_range(0, 63),
                       $urandom_range(0, 63));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request taken and answered, then watch for strays.
        while (pending_dates.size() != 0 || expected_epochs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_epochs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
